// ----- sv/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ID_BITS   = 16;
    localparam int PRIO_BITS = 16;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_CHANGE  = 2'd3
    } spq_cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } spq_status_t;

    typedef struct packed {
        spq_cmd_t               command;
        logic [ID_BITS-1:0]     item_id;
        logic [PRIO_BITS-1:0]   item_priority;
    } spq_in_t;

    typedef struct packed {
        spq_status_t            status;
        logic [ID_BITS-1:0]     out_id;
        logic [PRIO_BITS-1:0]   out_priority;
        logic [CNT_W-1:0]       rank;
        logic [CNT_W-1:0]       entry_count;
    } spq_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic remove;
        logic insert;
        logic extract;
        logic finish;
    } spq_ctrl_t;

endpackage

// ----- sv/spq_datapath.sv -----
`timescale 1ns / 1ps

module spq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  spq_pkg::spq_ctrl_t  ctrl,
    input  spq_pkg::spq_in_t    in_data,
    output spq_pkg::spq_out_t   out_data
);

    localparam int CAP = spq_pkg::CAPACITY;

    logic [spq_pkg::ID_BITS-1:0]   slot_id_reg   [CAP];
    logic [spq_pkg::PRIO_BITS-1:0] slot_prio_reg [CAP];
    logic [spq_pkg::ID_BITS-1:0]   above_id      [CAP];
    logic [spq_pkg::PRIO_BITS-1:0] above_prio    [CAP];
    logic [spq_pkg::ID_BITS-1:0]   below_id      [CAP];
    logic [spq_pkg::PRIO_BITS-1:0] below_prio    [CAP];

    logic [spq_pkg::CNT_W-1:0]     count_reg;
    spq_pkg::spq_cmd_t             cmd_reg;
    logic [spq_pkg::ID_BITS-1:0]   id_reg;
    logic [spq_pkg::PRIO_BITS-1:0] prio_reg;
    logic                          found_reg;
    logic                          full_reg;
    logic                          empty_reg;
    logic [spq_pkg::CNT_W-1:0]     rank_reg;
    logic [spq_pkg::ID_BITS-1:0]   head_id_reg;
    logic [spq_pkg::PRIO_BITS-1:0] head_prio_reg;
    spq_pkg::spq_out_t             out_reg;

    logic [CAP-1:0]                valid;
    logic [CAP-1:0]                hit_seen;
    logic [CAP-1:0]                less;
    logic                          found;
    logic                          is_full;
    logic                          is_empty;
    logic [spq_pkg::IDX_W-1:0]     ins_pos;
    spq_pkg::spq_status_t          status_next;

    // Neighbor taps for shifting toward and away from the head
    for (genvar g = 0; g < CAP; g++) begin : g_tap
        if (g == CAP - 1) begin : g_top
            assign above_id[g]   = slot_id_reg[g];
            assign above_prio[g] = slot_prio_reg[g];
        end else begin : g_mid
            assign above_id[g]   = slot_id_reg[g+1];
            assign above_prio[g] = slot_prio_reg[g+1];
        end
        if (g == 0) begin : g_head
            assign below_id[g]   = slot_id_reg[g];
            assign below_prio[g] = slot_prio_reg[g];
        end else begin : g_rest
            assign below_id[g]   = slot_id_reg[g-1];
            assign below_prio[g] = slot_prio_reg[g-1];
        end
    end

    always_comb begin
        for (int k = 0; k < CAP; k++) begin
            valid[k] = spq_pkg::CNT_W'(k) < count_reg;
            less[k]  = valid[k] && (slot_prio_reg[k] < prio_reg);
        end
        // Mark every slot at or past the first id match
        hit_seen[0] = valid[0] && (slot_id_reg[0] == id_reg);
        for (int k = 1; k < CAP; k++) begin
            hit_seen[k] = hit_seen[k-1] || (valid[k] && (slot_id_reg[k] == id_reg));
        end
        found = hit_seen[CAP-1];
        // Sorted table: slots below the new priority form a prefix
        ins_pos = '0;
        for (int k = CAP - 1; k >= 0; k--) begin
            if (!less[k]) begin
                ins_pos = spq_pkg::IDX_W'(k);
            end
        end
        is_full  = count_reg == spq_pkg::CNT_W'(CAP);
        is_empty = count_reg == '0;
    end

    always_comb begin
        case (cmd_reg)
            spq_pkg::CMD_INSERT:  status_next = full_reg ? spq_pkg::STATUS_FULL
                                                         : spq_pkg::STATUS_OK;
            spq_pkg::CMD_EXTRACT: status_next = empty_reg ? spq_pkg::STATUS_EMPTY
                                                          : spq_pkg::STATUS_OK;
            spq_pkg::CMD_REMOVE:  status_next = found_reg ? spq_pkg::STATUS_OK
                                                          : spq_pkg::STATUS_NOT_FOUND;
            spq_pkg::CMD_CHANGE: begin
                if (full_reg) begin
                    status_next = spq_pkg::STATUS_FULL;
                end else if (!found_reg) begin
                    status_next = spq_pkg::STATUS_NOT_FOUND;
                end else begin
                    status_next = spq_pkg::STATUS_OK;
                end
            end
            default: status_next = spq_pkg::STATUS_OK;
        endcase
    end

    // Slot storage: no reset, only slots below the count are ever read
    always_ff @(posedge aclk) begin
        for (int k = 0; k < CAP; k++) begin
            if (ctrl.remove && found && hit_seen[k]) begin
                slot_id_reg[k]   <= above_id[k];
                slot_prio_reg[k] <= above_prio[k];
            end else if (ctrl.extract && !is_empty) begin
                slot_id_reg[k]   <= above_id[k];
                slot_prio_reg[k] <= above_prio[k];
            end else if (ctrl.insert && !is_full) begin
                if (spq_pkg::IDX_W'(k) == ins_pos) begin
                    slot_id_reg[k]   <= id_reg;
                    slot_prio_reg[k] <= prio_reg;
                end else if (spq_pkg::IDX_W'(k) > ins_pos) begin
                    slot_id_reg[k]   <= below_id[k];
                    slot_prio_reg[k] <= below_prio[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.remove && found) begin
            count_reg <= count_reg - 1'b1;
        end else if (ctrl.extract && !is_empty) begin
            count_reg <= count_reg - 1'b1;
        end else if (ctrl.insert && !is_full) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg       <= in_data.command;
            id_reg        <= in_data.item_id;
            prio_reg      <= in_data.item_priority;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            rank_reg      <= '0;
            head_id_reg   <= '0;
            head_prio_reg <= '0;
        end
        if (ctrl.remove) begin
            found_reg <= found;
        end
        if (ctrl.insert) begin
            full_reg <= is_full;
            rank_reg <= is_full ? '0 : spq_pkg::CNT_W'(ins_pos) + 1'b1;
        end
        if (ctrl.extract) begin
            empty_reg <= is_empty;
            if (!is_empty) begin
                head_id_reg   <= slot_id_reg[0];
                head_prio_reg <= slot_prio_reg[0];
            end
        end
        if (ctrl.finish) begin
            out_reg.status       <= status_next;
            out_reg.out_id       <= head_id_reg;
            out_reg.out_priority <= head_prio_reg;
            out_reg.rank         <= rank_reg;
            out_reg.entry_count  <= count_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- sv/spq_controller.sv -----
`timescale 1ns / 1ps

module spq_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spq_pkg::spq_cmd_t   s_command,
    output logic                m_valid,
    input  logic                m_ready,
    output spq_pkg::spq_ctrl_t  ctrl
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_REMOVE  = 5'b00010,
        ST_INSERT  = 5'b00100,
        ST_EXTRACT = 5'b01000,
        ST_DONE    = 5'b10000
    } spq_state_t;

    spq_state_t        state_reg, state_next;
    spq_pkg::spq_cmd_t cmd_reg;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        ctrl.load    = s_valid && (state_reg == ST_IDLE);
        ctrl.remove  = state_reg == ST_REMOVE;
        ctrl.insert  = state_reg == ST_INSERT;
        ctrl.extract = state_reg == ST_EXTRACT;
        ctrl.finish  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        spq_pkg::CMD_INSERT:  state_next = ST_INSERT;
                        spq_pkg::CMD_EXTRACT: state_next = ST_EXTRACT;
                        default:              state_next = ST_REMOVE;
                    endcase
                end
            end
            // Change priority continues with an insert after the removal
            ST_REMOVE:  state_next = (cmd_reg == spq_pkg::CMD_CHANGE) ? ST_INSERT : ST_DONE;
            ST_INSERT:  state_next = ST_DONE;
            ST_EXTRACT: state_next = ST_DONE;
            ST_DONE: begin
                if (ctrl.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg <= s_command;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

// ----- sv/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps

// Sorted-list priority queue of up to CAPACITY (id, priority) entries, smallest
// priority at the head, a new entry placed ahead of equal priorities. Every
// command returns one result. Each command passes through accept, one table
// operation and a result stage that waits while the output register holds an
// untaken result; change priority has two table operations, its removal and
// reinsertion. All slots compare and shift in parallel within one operation,
// so its time does not depend on how full the table is. A result waiting in
// the output register does not block the next command from being accepted.
module sorted_priority_queue_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::spq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::spq_out_t m_data
);

    spq_pkg::spq_ctrl_t ctrl;

    spq_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ctrl      (ctrl)
    );

    spq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .in_data  (s_data),
        .out_data (m_data)
    );

    // A result is never loaded over one that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // One command at a time: acceptance closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

    // A dropped insert reports no rank
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == spq_pkg::STATUS_FULL)) |-> (m_data.rank == '0))
        else $error("rank reported for dropped entry");

    // Count never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.entry_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY)))
        else $error("entry count beyond capacity");

endmodule
